// File: hw/rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg: shared constants for the interval sigma clip statistics block
// Field widths, configuration register indexes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package isc_pkg;

    localparam int TS_W    = 64;
    localparam int IVL_W   = 24;
    localparam int VAR_W   = 48;
    localparam int KEPT_W  = 9;
    localparam int LAG_W   = 2;
    localparam int CLIP_W  = 12;
    localparam int CIDX_W  = 8;
    localparam int CDAT_W  = 16;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_IDX_LAG  = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_IDX_CLIP = 8'd1;

    localparam logic [LAG_W-1:0]  LAG_RESET  = 2'd1;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 12'd538;

    // The first difference in nanoseconds that saturates, and the bits of any
    // difference below it.
    localparam logic [TS_W-1:0] SAT_NS      = 64'd16777216000;
    localparam int              DIFF_BITS   = 34;
    localparam logic [IVL_W-1:0] IVL_MAX    = 24'hFFFFFF;

    // Nanoseconds to microseconds: the difference shifted right by three is
    // multiplied by ceil(2^38 / 125), which is exact for every 31-bit value.
    localparam logic [31:0] US_RCP    = 32'd2199023256;
    localparam int          US_RCP_SH = 38;

    // Square root iterations over a 48-bit radicand, two bits per step.
    localparam int SQ_STEPS = 24;

endpackage

// File: hw/rtl/isc_if.sv
// ----------------------------------------------------------------------------
// isc_if: channel interfaces for the interval sigma clip statistics block
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface isc_in_if;
    import isc_pkg::*;
    logic              valid;
    logic              ready;
    logic [TS_W-1:0]   timestamp_ns;
    logic              sample_present;
    logic              last_sample;

    modport source (output valid, timestamp_ns, sample_present, last_sample, input ready);
    modport sink   (input valid, timestamp_ns, sample_present, last_sample, output ready);
endinterface

interface isc_out_if;
    import isc_pkg::*;
    logic              valid;
    logic              ready;
    logic [IVL_W-1:0]  mean_us;
    logic [VAR_W-1:0]  variance_us2;
    logic [KEPT_W-1:0] kept_count;
    logic              no_data;

    modport source (output valid, mean_us, variance_us2, kept_count, no_data, input ready);
    modport sink   (input valid, mean_us, variance_us2, kept_count, no_data, output ready);
endinterface

interface isc_cfg_if;
    import isc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] idx;
    logic [CDAT_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

// File: hw/rtl/isc_ram.sv
// ----------------------------------------------------------------------------
// isc_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module isc_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/interval_sigma_clip_stats_top.sv
// ----------------------------------------------------------------------------
// interval_sigma_clip_stats_top: sigma clipped mean and variance of intervals
// Collects sample intervals of one batch and reports their clipped statistics.
// ----------------------------------------------------------------------------
// Each sample item forms the interval to the sample one back (lag 1) or two
// back (lag 2), in microseconds saturated at 24 bits, and stores it. The
// block takes one item at a time: an item that forms no interval is taken in
// the idle state alone, one whose interval saturates passes the write state,
// and any other interval is converted from nanoseconds by a reciprocal
// multiplication in the RCP state before the write state. The item with
// last_sample set starts clipping: each pass reads the stored intervals twice
// through the single interval RAM, runs the shared divider twice and the
// square root sequencer, and is repeated until a pass drops nothing, no
// interval is kept or sigma is 0. The result waits in an output register, so
// the next batch can start loading while it is still waiting to be taken.
// ----------------------------------------------------------------------------
module interval_sigma_clip_stats_top #(
    parameter int MAX_INTERVALS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    isc_in_if.sink      samples,
    isc_out_if.source   results,
    isc_cfg_if.sink     cfg
);
    import isc_pkg::*;

    // Widths that follow from the store depth.
    localparam int AW   = $clog2(MAX_INTERVALS);
    localparam int CW   = $clog2(MAX_INTERVALS + 1);
    localparam int SW   = IVL_W + CW;           // sum of intervals
    localparam int QW   = 2 * IVL_W + CW;       // sum of squared intervals
    localparam int DNW  = QW;                   // divider dividend
    localparam int DVW  = (CW > 10) ? CW : 10;  // divider divisor
    localparam int DCW  = $clog2(DNW + 1);
    localparam int NW   = (CW > KEPT_W) ? CW : KEPT_W;
    localparam int BW   = 38;                   // signed clipping bounds
    localparam int SCW  = $clog2(SQ_STEPS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WR      = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_FIN     = 4'd3;
    localparam logic [3:0] S_ACC_RD  = 4'd4;
    localparam logic [3:0] S_ACC_ADD = 4'd5;
    localparam logic [3:0] S_MM      = 4'd6;
    localparam logic [3:0] S_VAR     = 4'd7;
    localparam logic [3:0] S_SQRT    = 4'd8;
    localparam logic [3:0] S_KS      = 4'd9;
    localparam logic [3:0] S_DRP_RD  = 4'd10;
    localparam logic [3:0] S_DRP_CHK = 4'd11;
    localparam logic [3:0] S_EMIT    = 4'd12;
    localparam logic [3:0] S_RCP     = 4'd13;

    // What the divider result is used for.
    localparam logic [1:0] DIV_MEAN = 2'd1;
    localparam logic [1:0] DIV_SQ   = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [LAG_W-1:0]  lag_reg, lag_next;
    logic [CLIP_W-1:0] clip_reg, clip_next;
    logic [TS_W-1:0]   rec0_reg, rec0_next, rec1_reg, rec1_next;
    logic [1:0]        seen_reg, seen_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              last_reg, last_next;
    logic [IVL_W-1:0]  d_reg, d_next;
    logic [DIFF_BITS-4:0] ydiv_reg, ydiv_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [QW-1:0]     sumsq_reg, sumsq_next;
    logic [CW-1:0]     n_reg, n_next;
    logic              dropped_reg, dropped_next;
    logic              empty_reg, empty_next;
    logic [IVL_W-1:0]  mean_reg, mean_next;
    logic [VAR_W-1:0]  sq_reg, sq_next;
    logic [VAR_W-1:0]  mm_reg, mm_next;
    logic [VAR_W-1:0]  var_reg, var_next;
    logic [VAR_W-1:0]  sv_reg, sv_next;
    logic [VAR_W-1:0]  sres_reg, sres_next;
    logic [VAR_W-1:0]  sbit_reg, sbit_next;
    logic [SCW-1:0]    scnt_reg, scnt_next;
    logic signed [BW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [DNW-1:0]    div_num_reg, div_num_next;
    logic [DNW-1:0]    div_quo_reg, div_quo_next;
    logic [DVW-1:0]    div_rem_reg, div_rem_next;
    logic [DVW-1:0]    div_den_reg, div_den_next;
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;
    logic [1:0]        div_ret_reg, div_ret_next;
    logic              ov_reg, ov_next;
    logic [IVL_W-1:0]  omean_reg, omean_next;
    logic [VAR_W-1:0]  ovar_reg, ovar_next;
    logic [KEPT_W-1:0] okept_reg, okept_next;
    logic              onodata_reg, onodata_next;

    // RAM port signals; each entry holds the kept mark above the interval.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [IVL_W:0]     ram_wdata;
    logic [IVL_W:0]     ram_rdata;

    logic               in_acc;
    logic               can_emit;
    logic               lag_two;
    logic [TS_W-1:0]    diff;
    logic [TS_W-1:0]    rcp_prod;
    logic [DVW:0]       rem_sh;
    logic               rem_ge;
    logic [VAR_W-1:0]   sq_try;
    logic [IVL_W-1:0]   x;
    logic [2*IVL_W-1:0] xx;
    logic signed [BW-1:0] x8;
    logic               x_drop;
    logic [CW-1:0]      j_inc;
    logic               j_last;
    logic [CLIP_W+IVL_W-1:0] ks;
    logic signed [BW-1:0] m8;
    logic [NW-1:0]      n_wide;

    isc_ram #(
        .WIDTH (IVL_W + 1),
        .DEPTH (MAX_INTERVALS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (j_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign samples.ready        = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign results.valid        = ov_reg;
    assign results.mean_us      = omean_reg;
    assign results.variance_us2 = ovar_reg;
    assign results.kept_count   = okept_reg;
    assign results.no_data      = onodata_reg;

    assign in_acc   = samples.valid && (state_reg == S_IDLE);
    assign can_emit = !ov_reg || results.ready;

    // Lag codes 0 and 1 mean one sample back; 2 and 3 mean two back.
    assign lag_two = lag_reg[1];
    assign diff    = samples.timestamp_ns - (lag_two ? rec1_reg : rec0_reg);

    // Reciprocal product for the nanosecond to microsecond conversion.
    assign rcp_prod = ydiv_reg * US_RCP;

    // Restoring divider step, one quotient bit per cycle.
    assign rem_sh = {div_rem_reg, div_num_reg[DNW-1]};
    assign rem_ge = (rem_sh >= {1'b0, div_den_reg});

    assign sq_try = sres_reg + sbit_reg;

    assign x      = ram_rdata[IVL_W-1:0];
    assign xx     = x * x;
    assign x8     = $signed({{(BW-IVL_W-8){1'b0}}, x, 8'd0});
    assign x_drop = ram_rdata[IVL_W] && ((x8 <= lo_reg) || (hi_reg <= x8));
    assign j_inc  = j_reg + 1'b1;
    assign j_last = (j_inc == count_reg);

    assign ks     = clip_reg * sres_reg[IVL_W-1:0];
    assign m8     = $signed({{(BW-IVL_W-8){1'b0}}, mean_reg, 8'd0});
    assign n_wide = NW'(n_reg);

    always_comb
    begin
        state_next   = state_reg;
        lag_next     = lag_reg;
        clip_next    = clip_reg;
        rec0_next    = rec0_reg;
        rec1_next    = rec1_reg;
        seen_next    = seen_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        d_next       = d_reg;
        ydiv_next    = ydiv_reg;
        j_next       = j_reg;
        sum_next     = sum_reg;
        sumsq_next   = sumsq_reg;
        n_next       = n_reg;
        dropped_next = dropped_reg;
        empty_next   = empty_reg;
        mean_next    = mean_reg;
        sq_next      = sq_reg;
        mm_next      = mm_reg;
        var_next     = var_reg;
        sv_next      = sv_reg;
        sres_next    = sres_reg;
        sbit_next    = sbit_reg;
        scnt_next    = scnt_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        div_num_next = div_num_reg;
        div_quo_next = div_quo_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        div_cnt_next = div_cnt_reg;
        div_ret_next = div_ret_reg;
        ov_next      = ov_reg;
        omean_next   = omean_reg;
        ovar_next    = ovar_reg;
        okept_next   = okept_reg;
        onodata_next = onodata_reg;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[AW-1:0];
        ram_wdata    = {1'b1, d_reg};

        if (ov_reg && results.ready)
        begin
            ov_next = 1'b0;
        end

        if (cfg.valid)
        begin
            if (cfg.idx == CFG_IDX_LAG)
            begin
                lag_next = cfg.data[LAG_W-1:0];
            end
            else if (cfg.idx == CFG_IDX_CLIP)
            begin
                clip_next = cfg.data[CLIP_W-1:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    last_next = samples.last_sample;
                    state_next = samples.last_sample ? S_FIN : S_IDLE;
                    if (samples.sample_present)
                    begin
                        rec1_next = rec0_reg;
                        rec0_next = samples.timestamp_ns;
                        if (seen_reg != 2'd2)
                        begin
                            seen_next = seen_reg + 2'd1;
                        end
                        if ((seen_reg > {1'b0, lag_two}) &&
                            (count_reg < CW'(MAX_INTERVALS)))
                        begin
                            if (diff >= SAT_NS)
                            begin
                                d_next     = IVL_MAX;
                                state_next = S_WR;
                            end
                            else
                            begin
                                ydiv_next  = diff[DIFF_BITS-1:3];
                                state_next = S_RCP;
                            end
                        end
                    end
                end
            end

            S_RCP:
            begin
                d_next     = rcp_prod[US_RCP_SH+IVL_W-1:US_RCP_SH];
                state_next = S_WR;
            end

            S_WR:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = last_reg ? S_FIN : S_IDLE;
            end

            S_DIV:
            begin
                div_num_next = div_num_reg << 1;
                div_rem_next = rem_ge ? DVW'(rem_sh - {1'b0, div_den_reg})
                                      : rem_sh[DVW-1:0];
                div_quo_next = {div_quo_reg[DNW-2:0], rem_ge};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == DCW'(1))
                begin
                    case (div_ret_reg)
                        DIV_MEAN:
                        begin
                            mean_next    = div_quo_next[IVL_W-1:0];
                            div_num_next = sumsq_reg;
                            div_rem_next = '0;
                            div_cnt_next = DCW'(QW);
                            div_ret_next = DIV_SQ;
                        end
                        default:
                        begin
                            sq_next    = div_quo_next[VAR_W-1:0];
                            state_next = S_MM;
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                if (count_reg == '0)
                begin
                    mean_next  = '0;
                    var_next   = '0;
                    n_next     = '0;
                    empty_next = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    empty_next = 1'b0;
                    j_next     = '0;
                    sum_next   = '0;
                    sumsq_next = '0;
                    n_next     = '0;
                    state_next = S_ACC_RD;
                end
            end

            S_ACC_RD:
            begin
                state_next = S_ACC_ADD;
            end

            S_ACC_ADD:
            begin
                if (ram_rdata[IVL_W])
                begin
                    sum_next   = sum_reg + SW'(x);
                    sumsq_next = sumsq_reg + QW'(xx);
                    n_next     = n_reg + 1'b1;
                end
                j_next     = j_inc;
                state_next = S_ACC_RD;
                if (j_last)
                begin
                    if (n_next == '0)
                    begin
                        // Every interval has been dropped.
                        mean_next  = '0;
                        var_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        div_num_next = {sum_next, {(DNW-SW){1'b0}}};
                        div_den_next = DVW'(n_next);
                        div_rem_next = '0;
                        div_cnt_next = DCW'(SW);
                        div_ret_next = DIV_MEAN;
                        state_next   = S_DIV;
                    end
                end
            end

            S_MM:
            begin
                mm_next    = mean_reg * mean_reg;
                state_next = S_VAR;
            end

            S_VAR:
            begin
                var_next   = (sq_reg > mm_reg) ? sq_reg - mm_reg : '0;
                sv_next    = var_next;
                sres_next  = '0;
                sbit_next  = VAR_W'(1) << (VAR_W - 2);
                scnt_next  = SCW'(SQ_STEPS);
                state_next = S_SQRT;
            end

            S_SQRT:
            begin
                if (sv_reg >= sq_try)
                begin
                    sv_next   = sv_reg - sq_try;
                    sres_next = (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_next = sres_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
                scnt_next = scnt_reg - 1'b1;
                if (scnt_reg == SCW'(1))
                begin
                    state_next = S_KS;
                end
            end

            S_KS:
            begin
                // A zero sigma would drop everything, so clipping ends here.
                if (sres_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    lo_next      = m8 - $signed(BW'(ks));
                    hi_next      = m8 + $signed(BW'(ks));
                    j_next       = '0;
                    dropped_next = 1'b0;
                    state_next   = S_DRP_RD;
                end
            end

            S_DRP_RD:
            begin
                state_next = S_DRP_CHK;
            end

            S_DRP_CHK:
            begin
                if (x_drop)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = j_reg[AW-1:0];
                    ram_wdata    = {1'b0, x};
                    dropped_next = 1'b1;
                end
                j_next     = j_inc;
                state_next = S_DRP_RD;
                if (j_last)
                begin
                    if (dropped_next)
                    begin
                        j_next     = '0;
                        sum_next   = '0;
                        sumsq_next = '0;
                        n_next     = '0;
                        state_next = S_ACC_RD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (can_emit)
                begin
                    ov_next      = 1'b1;
                    omean_next   = mean_reg;
                    ovar_next    = var_reg;
                    okept_next   = n_wide[KEPT_W-1:0];
                    onodata_next = empty_reg;
                    rec0_next    = '0;
                    rec1_next    = '0;
                    seen_next    = '0;
                    count_next   = '0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lag_reg     <= LAG_RESET;
            clip_reg    <= CLIP_RESET;
            rec0_reg    <= '0;
            rec1_reg    <= '0;
            seen_reg    <= '0;
            count_reg   <= '0;
            last_reg    <= 1'b0;
            j_reg       <= '0;
            n_reg       <= '0;
            dropped_reg <= 1'b0;
            empty_reg   <= 1'b0;
            scnt_reg    <= '0;
            div_cnt_reg <= '0;
            div_ret_reg <= DIV_MEAN;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lag_reg     <= lag_next;
            clip_reg    <= clip_next;
            rec0_reg    <= rec0_next;
            rec1_reg    <= rec1_next;
            seen_reg    <= seen_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            dropped_reg <= dropped_next;
            empty_reg   <= empty_next;
            scnt_reg    <= scnt_next;
            div_cnt_reg <= div_cnt_next;
            div_ret_reg <= div_ret_next;
            ov_reg      <= ov_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        ydiv_reg    <= ydiv_next;
        sum_reg     <= sum_next;
        sumsq_reg   <= sumsq_next;
        mean_reg    <= mean_next;
        sq_reg      <= sq_next;
        mm_reg      <= mm_next;
        var_reg     <= var_next;
        sv_reg      <= sv_next;
        sres_reg    <= sres_next;
        sbit_reg    <= sbit_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        div_num_reg <= div_num_next;
        div_quo_reg <= div_quo_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        omean_reg   <= omean_next;
        ovar_reg    <= ovar_next;
        okept_reg   <= okept_next;
        onodata_reg <= onodata_next;
    end

    // An empty batch reports all zero statistics.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && onodata_reg) |-> (okept_reg == '0 && omean_reg == '0 && ovar_reg == '0))
        else $error("empty batch result carries nonzero statistics");

    // The store never holds more intervals than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_INTERVALS))
        else $error("interval count beyond store depth");

    // Emitting a result clears the batch for the next one.
    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && can_emit) |=> (count_reg == '0 && seen_reg == '0 && ov_reg))
        else $error("batch state not cleared after result");

    // A clipping bound is only formed from a nonempty kept set.
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KS) |-> (n_reg != '0 && n_reg <= count_reg))
        else $error("kept count out of range during clipping");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for interval_sigma_clip_stats_top
// Drives batches of timestamps under several lag and clip settings with random
// idling on both channels, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import isc_pkg::*;

    localparam int DEPTH        = 256;
    // Idle cycles between the last result of a phase and a register write.
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [TS_W-1:0] ts;
        logic            present;
        logic            last;
    } sample_t;

    typedef struct {
        logic [IVL_W-1:0]  mean;
        logic [VAR_W-1:0]  variance;
        logic [KEPT_W-1:0] kept;
        logic              no_data;
    } stats_t;

    logic clk;
    logic rst_n;

    isc_in_if  in_ch ();
    isc_out_if out_ch ();
    isc_cfg_if cfg_ch ();

    interval_sigma_clip_stats_top #(.MAX_INTERVALS(DEPTH)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_ch),
        .results (out_ch),
        .cfg     (cfg_ch)
    );

    // Items waiting to be driven and statistics waiting to come out.
    sample_t sample_q[$];
    stats_t  stats_q[$];
    sample_t cur_sample;

    // Shadow copy of the block's configuration and batch state.
    logic [LAG_W-1:0]  lag_reg;
    logic [CLIP_W-1:0] clip_reg;
    logic [IVL_W-1:0]  ivl_mem[DEPTH];
    bit                keep_mem[DEPTH];
    logic [TS_W-1:0]   last_ts[2];
    int unsigned       seen_cnt;
    int unsigned       ivl_cnt;

    int sender_idle;
    int recv_idle;
    int errors;
    int items_taken;
    int results_seen;
    int empty_results;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A generous bound on the whole run.
    initial begin
        #100ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Fold one accepted item into the shadow state; a last item yields the
    // expected statistics, computed with the same clipping passes as the block.
    function automatic void track_sample(input sample_t it);
        int unsigned       lag;
        longint unsigned   d;
        longint unsigned   sum;
        longint unsigned   sumsq;
        longint unsigned   n;
        longint unsigned   mean;
        longint unsigned   sq;
        longint unsigned   var_v;
        longint unsigned   rem;
        longint unsigned   root;
        longint unsigned   bitv;
        longint            ks;
        longint            m8;
        longint            x8;
        bit                dropped;
        stats_t            st;
        if (it.present) begin
            lag = (lag_reg == 2'd0) ? 1 : ((lag_reg == 2'd3) ? 2 : int'(lag_reg));
            if (seen_cnt >= lag && ivl_cnt < DEPTH) begin
                d = (it.ts - last_ts[lag-1]) / 1000;
                if (d > 64'hFFFFFF)
                    d = 64'hFFFFFF;
                ivl_mem[ivl_cnt]  = d[IVL_W-1:0];
                keep_mem[ivl_cnt] = 1'b1;
                ivl_cnt++;
            end
            last_ts[1] = last_ts[0];
            last_ts[0] = it.ts;
            if (seen_cnt < 511)
                seen_cnt++;
        end
        if (!it.last)
            return;
        if (ivl_cnt == 0) begin
            st.mean = '0;
            st.variance = '0;
            st.kept = '0;
            st.no_data = 1'b1;
        end else begin
            mean = 0;
            var_v = 0;
            n = 0;
            do begin
                dropped = 1'b0;
                sum = 0;
                sumsq = 0;
                n = 0;
                for (int j = 0; j < ivl_cnt; j++) begin
                    if (keep_mem[j]) begin
                        sum += ivl_mem[j];
                        sumsq += longint'(ivl_mem[j]) * longint'(ivl_mem[j]);
                        n++;
                    end
                end
                if (n == 0) begin
                    mean = 0;
                    var_v = 0;
                    break;
                end
                mean = sum / n;
                sq = sumsq / n;
                var_v = (sq > mean * mean) ? sq - mean * mean : 0;
                // Integer square root, two bits per step.
                rem = var_v;
                root = 0;
                bitv = 64'd1 << 62;
                while (bitv > rem)
                    bitv >>= 2;
                while (bitv != 0) begin
                    if (rem >= root + bitv) begin
                        rem -= root + bitv;
                        root = (root >> 1) + bitv;
                    end else begin
                        root >>= 1;
                    end
                    bitv >>= 2;
                end
                if (root == 0)
                    break;
                ks = longint'(clip_reg) * longint'(root);
                m8 = longint'(mean << 8);
                for (int j = 0; j < ivl_cnt; j++) begin
                    if (keep_mem[j]) begin
                        x8 = longint'(ivl_mem[j]) << 8;
                        if (x8 <= m8 - ks || m8 + ks <= x8) begin
                            keep_mem[j] = 1'b0;
                            dropped = 1'b1;
                        end
                    end
                end
            end while (dropped);
            st.mean = mean[IVL_W-1:0];
            st.variance = var_v[VAR_W-1:0];
            st.kept = n[KEPT_W-1:0];
            st.no_data = 1'b0;
        end
        stats_q = {stats_q, st};
        last_ts[0] = '0;
        last_ts[1] = '0;
        seen_cnt = 0;
        ivl_cnt = 0;
    endfunction

    // Sample driver: holds an item until it is taken, idles at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_ch.valid          <= 1'b0;
            in_ch.timestamp_ns   <= '0;
            in_ch.sample_present <= 1'b0;
            in_ch.last_sample    <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                track_sample(cur_sample);
                items_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
                    cur_sample = sample_q.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.timestamp_ns   <= cur_sample.ts;
                    in_ch.sample_present <= cur_sample.present;
                    in_ch.last_sample    <= cur_sample.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure, compares against the oldest
    // expected statistics.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (stats_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result mean %0d var %0d kept %0d no_data %0d",
                             $time, out_ch.mean_us, out_ch.variance_us2,
                             out_ch.kept_count, out_ch.no_data);
                end else begin
                    stats_t e;
                    e = stats_q.pop_front();
                    if (e.no_data)
                        empty_results++;
                    if (out_ch.mean_us !== e.mean) begin
                        errors++;
                        $display("%0t: mean_us expected %0d actual %0d",
                                 $time, e.mean, out_ch.mean_us);
                    end
                    if (out_ch.variance_us2 !== e.variance) begin
                        errors++;
                        $display("%0t: variance_us2 expected %0d actual %0d",
                                 $time, e.variance, out_ch.variance_us2);
                    end
                    if (out_ch.kept_count !== e.kept) begin
                        errors++;
                        $display("%0t: kept_count expected %0d actual %0d",
                                 $time, e.kept, out_ch.kept_count);
                    end
                    if (out_ch.no_data !== e.no_data) begin
                        errors++;
                        $display("%0t: no_data expected %0d actual %0d",
                                 $time, e.no_data, out_ch.no_data);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic push_sample(input logic [TS_W-1:0] ts, input bit present, input bit last);
        sample_t s;
        s.ts = ts;
        s.present = present;
        s.last = last;
        sample_q = {sample_q, s};
    endtask

    // One well-formed batch of n samples with random spacing, jitter and
    // occasional outliers, backward steps, huge gaps and noise items.
    task automatic push_batch(input int n);
        logic [TS_W-1:0] t;
        longint unsigned step;
        bit              closer;
        t = {$urandom, $urandom};
        case ($urandom_range(2))
            0: step = $urandom_range(2000);
            1: step = longint'($urandom_range(3000)) * 1000 + $urandom_range(999);
            default: step = longint'($urandom_range(16000)) * 1000000;
        endcase
        closer = ($urandom_range(7) == 0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                push_sample({$urandom, $urandom}, 1'b0, 1'b0);
            case ($urandom_range(59))
                0: t = t - $urandom_range(100000);
                1: t = t + 64'd17000000000 + {$urandom, $urandom} % 64'd1000000000000;
                2, 3, 4: t = t + step * $urandom_range(20, 3);
                default: t = t + step + $urandom_range(int'(step / 8));
            endcase
            push_sample(t, 1'b1, (i == n - 1) && !closer);
        end
        if (closer)
            push_sample({$urandom, $urandom}, 1'b0, 1'b1);
    endtask

    // Wait until everything queued has gone through, then let the block settle.
    task automatic drain();
        while (sample_q.size() > 0 || in_ch.valid || stats_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_IDX_LAG)
            lag_reg = value[LAG_W-1:0];
        else if (idx == CFG_IDX_CLIP)
            clip_reg = value[CLIP_W-1:0];
    endtask

    task automatic random_items(input int target);
        int start;
        start = sample_q.size();
        while (sample_q.size() - start < target) begin
            // Mostly short batches; an occasional empty one.
            if ($urandom_range(15) == 0)
                push_sample({$urandom, $urandom}, 1'b0, 1'b1);
            else
                push_batch($urandom_range(24, 1));
        end
    endtask

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.idx   = '0;
        cfg_ch.data  = '0;
        rst_n = 1'b0;
        errors = 0;
        items_taken = 0;
        results_seen = 0;
        empty_results = 0;
        lag_reg = LAG_RESET;
        clip_reg = CLIP_RESET;
        last_ts[0] = '0;
        last_ts[1] = '0;
        seen_cnt = 0;
        ivl_cnt = 0;
        sender_idle = 34;
        recv_idle = 59;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed batches under the reset settings.
        push_sample({$urandom, $urandom}, 1'b0, 1'b1);           // empty batch
        push_sample(64'd0, 1'b1, 1'b1);                          // one sample, no interval
        push_sample({$urandom, $urandom}, 1'b0, 1'b0);           // ignored noise item
        push_sample(64'd0, 1'b1, 1'b0);                          // widest gap saturates
        push_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++)                              // equal stamps, zero sigma
            push_sample(64'd123456789, 1'b1, i == 3);
        push_sample(64'd5000000, 1'b1, 1'b0);                    // backward step wraps
        push_sample(64'd1000, 1'b1, 1'b1);
        for (int i = 0; i < 7; i++)                              // one far outlier clipped
            push_sample(64'd1000000 * i + 64'd37 * i * i, 1'b1, 1'b0);
        push_sample(64'd60000000, 1'b1, 1'b1);
        drain();

        // Each phase starts from an idle block with new register values.
        for (int ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: begin write_reg(CFG_IDX_LAG, 16'd2); write_reg(CFG_IDX_CLIP, 16'd538); end
                2: begin write_reg(CFG_IDX_LAG, 16'd0); write_reg(CFG_IDX_CLIP, 16'd1); end
                3: begin write_reg(CFG_IDX_LAG, 16'd3); write_reg(CFG_IDX_CLIP, 16'd4095); end
                4: begin
                    write_reg(CFG_IDX_LAG, 16'd1);
                    write_reg(CFG_IDX_CLIP, 16'($urandom_range(800, 200)));
                end
                default: begin
                    // Upper data bits carry noise the register must ignore.
                    write_reg(CFG_IDX_LAG, {14'($urandom), 2'd2});
                    write_reg(CFG_IDX_CLIP, {4'($urandom), 12'd538});
                end
            endcase
            if (ph == 2 || ph == 3) begin
                sender_idle = 59;
                recv_idle = 34;
            end else if (ph >= 4) begin
                sender_idle = 0;
                recv_idle = 0;
            end
            if (ph == 4)
                push_batch(262);                                 // overfills the store
            random_items((ph == 4) ? 80 : 150);
            drain();
        end

        $display("Accepted %0d items and checked %0d results (%0d empty batches)",
                 items_taken, results_seen, empty_results);
        $display("Covered both lags, out-of-range lags and clip factors from 1 to 4095");
        if (errors == 0 && stats_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/isc_pkg.sv
hw/rtl/isc_if.sv
hw/rtl/isc_ram.sv
hw/rtl/interval_sigma_clip_stats_top.sv
bench/tb.sv
